// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the ready queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/aprq_pkg.sv =====
// ----------------------------------------------------------------------------
// Ready queue package
// Field widths, codes and shared types of the aging priority ready queue.
// ----------------------------------------------------------------------------
package aprq_pkg;

   localparam int ID_FIELD_W = 8;
   localparam int PRIO_W     = 32;
   localparam int STAMP_W    = 32;
   localparam int WEIGHT_W   = 16;
   localparam int VALUE_W    = 48;

   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [0:0] {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_AGING_MODE = 1'b0,
      CSR_AGE_WEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_tag_type;

endpackage

// ===== rtl/aging_priority_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// Aging priority ready queue
// Process entries in arrival order, dequeued by head or by aged priority.
// ----------------------------------------------------------------------------
// The entries live in one memory with a single write port and a single
// registered read port, and that read port sets the pace. A dequeue of a
// queue holding N entries reads the candidates (N in aging mode, one in
// head mode) at one per cycle through the scan pipeline, then closes the
// gap by moving the N - 1 - p entries behind the chosen slot p up by one
// place at one per cycle, and then hands over the result; when the chosen
// entry is the last one, nothing has to move. A new request is taken once
// the previous one has finished, even while its result beat still waits
// on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aging_priority_ready_queue_top #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_WIDTH    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // process_id[7:0], base_priority[39:8], arrival_stamp[71:40],
   // sched_now[103:72]
   input  logic [aprq_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic [aprq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // chosen_id[7:0], new_priority[55:8]
   output logic [aprq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_valid[0], status[2:1]
   output logic [aprq_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic [aprq_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [aprq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import aprq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_COMPACT = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [PRIO_W-1:0]   prio;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   req_kind_type          req_kind;
   logic [ID_FIELD_W-1:0] in_pid;
   logic [PRIO_W-1:0]     in_prio;
   logic [STAMP_W-1:0]    in_stamp;
   logic [STAMP_W-1:0]    in_now;

   state_type             state_ff, state_in;
   logic [CW-1:0]         entry_count_ff, entry_count_in;
   logic                  aging_mode_ff, aging_mode_in;
   logic [WEIGHT_W-1:0]   age_weight_ff, age_weight_in;
   logic [STAMP_W-1:0]    now_ff, now_in;
   logic [CW-1:0]         scan_len_ff, scan_len_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic [CW-1:0]         mv_rd_ff, mv_rd_in;
   logic                  cp_valid_ff, cp_valid_in;
   logic [AW-1:0]         cp_wr_ff, cp_wr_in;
   scan_tag_type          scan_tag_ff, scan_tag_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ID_FIELD_W-1:0] pend_id_ff, pend_id_in;
   logic [VALUE_W-1:0]    pend_value_ff, pend_value_in;
   status_type            pend_status_ff, pend_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   entry_type             mem [QUEUE_DEPTH];
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   entry_type             rd_data_ff;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;

   logic [WEIGHT_W-1:0]   weight_eff;
   logic                  best_done;
   logic [AW-1:0]         best_idx;
   logic [ID_WIDTH-1:0]   best_id;
   logic [VALUE_W-1:0]    best_value;

   logic                  pipe_busy;
   logic                  enq_ok;
   logic [CW-1:0]         count_up;
   logic                  count_ok;

   assign req_kind = req_kind_type'(req_tuser[0]);
   assign in_pid   = req_tdata[7:0];
   assign in_prio  = req_tdata[39:8];
   assign in_stamp = req_tdata[71:40];
   assign in_now   = req_tdata[103:72];

   assign weight_eff = aging_mode_ff ? age_weight_ff : '0;
   assign req_tready = (state_ff == ST_IDLE);

   aprq_age_unit #(
      .ID_WIDTH   (ID_WIDTH),
      .ADDR_WIDTH (AW)
   ) u_age (
      .clock       (clock),
      .reset       (reset),
      .tag         (scan_tag_ff),
      .entry_id    (rd_data_ff.id),
      .entry_prio  (rd_data_ff.prio),
      .entry_stamp (rd_data_ff.stamp),
      .now         (now_ff),
      .weight      (weight_eff),
      .best_done   (best_done),
      .best_idx    (best_idx),
      .best_id     (best_id),
      .best_value  (best_value)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      aging_mode_in  = aging_mode_ff;
      age_weight_in  = age_weight_ff;
      now_in         = now_ff;
      scan_len_in    = scan_len_ff;
      issue_in       = issue_ff;
      mv_rd_in       = mv_rd_ff;
      cp_valid_in    = 1'b0;
      cp_wr_in       = cp_wr_ff;
      scan_tag_in    = '0;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = entry_count_ff[AW-1:0];
      wr_data.id     = ID_WIDTH'(in_pid);
      wr_data.prio   = in_prio;
      wr_data.stamp  = in_stamp;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pend_valid_in  = 1'b0;
               pend_id_in     = '0;
               pend_value_in  = '0;
               pend_status_in = STATUS_OK;
               state_in       = ST_FINISH;
               if (req_kind == REQ_ENQUEUE) begin
                  if (entry_count_ff == DEPTH_CNT) begin
                     pend_status_in = STATUS_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     entry_count_in = entry_count_ff + ONE_CNT;
                  end
               end else if (entry_count_ff == '0) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  now_in            = in_now;
                  scan_len_in       = aging_mode_ff ? entry_count_ff : ONE_CNT;
                  rd_en             = 1'b1;
                  rd_addr           = '0;
                  scan_tag_in.valid = 1'b1;
                  scan_tag_in.first = 1'b1;
                  scan_tag_in.last  = !aging_mode_ff || (entry_count_ff == ONE_CNT);
                  issue_in          = ONE_CNT;
                  state_in          = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < scan_len_ff) begin
               rd_en             = 1'b1;
               rd_addr           = issue_ff[AW-1:0];
               scan_tag_in.valid = 1'b1;
               scan_tag_in.last  = (issue_ff == (scan_len_ff - ONE_CNT));
               issue_in          = issue_ff + ONE_CNT;
            end
            if (best_done) begin
               pend_valid_in  = 1'b1;
               pend_id_in     = ID_FIELD_W'(best_id);
               pend_value_in  = best_value;
               pend_status_in = STATUS_OK;
               mv_rd_in       = CW'(best_idx) + ONE_CNT;
               state_in       = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            if (mv_rd_ff < entry_count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = mv_rd_ff[AW-1:0];
               cp_valid_in = 1'b1;
               cp_wr_in    = AW'(mv_rd_ff - ONE_CNT);
               mv_rd_in    = mv_rd_ff + ONE_CNT;
            end
            if (cp_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = cp_wr_ff;
               wr_data = rd_data_ff;
            end
            if (!(mv_rd_ff < entry_count_ff) && !cp_valid_ff) begin
               entry_count_in = entry_count_ff - ONE_CNT;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pend_value_ff, pend_id_ff};
               rsp_user_in  = {pend_status_ff, pend_valid_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_AGING_MODE: aging_mode_in = csr_wdata[0];
            CSR_AGE_WEIGHT: age_weight_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         aging_mode_ff  <= 1'b0;
         age_weight_ff  <= '0;
         scan_len_ff    <= '0;
         issue_ff       <= '0;
         mv_rd_ff       <= '0;
         cp_valid_ff    <= 1'b0;
         scan_tag_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         aging_mode_ff  <= aging_mode_in;
         age_weight_ff  <= age_weight_in;
         scan_len_ff    <= scan_len_in;
         issue_ff       <= issue_in;
         mv_rd_ff       <= mv_rd_in;
         cp_valid_ff    <= cp_valid_in;
         scan_tag_ff    <= scan_tag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      cp_wr_ff       <= cp_wr_in;
      pend_valid_ff  <= pend_valid_in;
      pend_id_ff     <= pend_id_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign pipe_busy = cp_valid_ff || scan_tag_ff.valid || best_done;
   assign enq_ok    = req_tvalid && req_tready && (req_kind == REQ_ENQUEUE) &&
                      (entry_count_ff != DEPTH_CNT);
   assign count_up  = entry_count_ff + ONE_CNT;
   assign count_ok  = (entry_count_ff <= DEPTH_CNT);

   `APRQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ok, "entry count over depth")
   `APRQ_ASSERT_SAME(a_idle_drained, clock, reset, req_tready, !pipe_busy, "pipeline busy in idle")
   `APRQ_ASSERT_SAME(a_done_scan, clock, reset, best_done, state_ff == ST_SCAN, "stray scan result")
   `APRQ_ASSERT_NEXT(a_enq_grow, clock, reset, enq_ok, entry_count_ff == $past(count_up), "lost enqueue")

endmodule

// ===== rtl/aprq_age_unit.sv =====
// ----------------------------------------------------------------------------
// Aged priority scan unit
// Computes the aged value of each scanned entry in two stages and tracks the
// smallest one, the earliest entry winning a tie.
// ----------------------------------------------------------------------------
module aprq_age_unit #(
   parameter int ID_WIDTH   = 8,
   parameter int ADDR_WIDTH = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aprq_pkg::scan_tag_type        tag,
   input  logic [ID_WIDTH-1:0]           entry_id,
   input  logic [aprq_pkg::PRIO_W-1:0]   entry_prio,
   input  logic [aprq_pkg::STAMP_W-1:0]  entry_stamp,
   input  logic [aprq_pkg::STAMP_W-1:0]  now,
   input  logic [aprq_pkg::WEIGHT_W-1:0] weight,
   output logic                          best_done,
   output logic [ADDR_WIDTH-1:0]         best_idx,
   output logic [ID_WIDTH-1:0]           best_id,
   output logic [aprq_pkg::VALUE_W-1:0]  best_value
);
   import aprq_pkg::*;

   logic [STAMP_W-1:0]    waited;
   logic [VALUE_W-1:0]    product;
   scan_tag_type          a_tag_ff;
   logic [VALUE_W-1:0]    a_mult_ff;
   logic [PRIO_W-1:0]     a_prio_ff;
   logic [ID_WIDTH-1:0]   a_id_ff;
   logic [VALUE_W-1:0]    aged;
   logic [ADDR_WIDTH-1:0] cur_idx;
   logic [ADDR_WIDTH-1:0] next_idx_ff;
   logic                  take;
   logic                  done_ff;
   logic [ADDR_WIDTH-1:0] best_idx_ff;
   logic [ID_WIDTH-1:0]   best_id_ff;
   logic [VALUE_W-1:0]    best_value_ff;

   assign waited  = now - entry_stamp;
   assign product = VALUE_W'(waited) * VALUE_W'(weight);

   assign aged    = VALUE_W'(a_prio_ff) + a_mult_ff;
   assign cur_idx = a_tag_ff.first ? '0 : next_idx_ff;
   assign take    = a_tag_ff.valid && (a_tag_ff.first || (aged < best_value_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         a_tag_ff <= tag;
         done_ff  <= a_tag_ff.valid && a_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      a_mult_ff <= product;
      a_prio_ff <= entry_prio;
      a_id_ff   <= entry_id;
      if (a_tag_ff.valid) begin
         next_idx_ff <= cur_idx + ADDR_WIDTH'(1);
      end
      if (take) begin
         best_value_ff <= aged;
         best_idx_ff   <= cur_idx;
         best_id_ff    <= a_id_ff;
      end
   end

   assign best_done  = done_ff;
   assign best_idx   = best_idx_ff;
   assign best_id    = best_id_ff;
   assign best_value = best_value_ff;

endmodule

// ===== tb/tb_aging_priority_ready_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ready queue testbench
// Drives enqueue and dequeue beats into the aging priority ready queue under
// random idling and output back-pressure, keeps its own copy of the queue
// and the scheduler settings, and checks every response beat field by field
// against the entry that the scheduler should have picked.
// ----------------------------------------------------------------------------
module tb_aging_priority_ready_queue_top;
   import aprq_pkg::*;

   localparam int QUEUE_DEPTH      = 32;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES      = 80;

   typedef struct {
      req_kind_type            kind;
      logic [ID_FIELD_W-1:0]   pid;
      logic [PRIO_W-1:0]       prio;
      logic [STAMP_W-1:0]      stamp;
      logic [STAMP_W-1:0]      now;
   } sched_req_type;

   typedef struct {
      logic                    ok;
      logic [ID_FIELD_W-1:0]   id;
      logic [VALUE_W-1:0]      prio;
      status_type              status;
   } sched_rsp_type;

   typedef struct {
      logic [ID_FIELD_W-1:0]   id;
      logic [PRIO_W-1:0]       prio;
      logic [STAMP_W-1:0]      stamp;
   } ready_entry_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ready_entry_type       rq_entries[$];
   logic                  rq_aging;
   logic [WEIGHT_W-1:0]   rq_weight;
   sched_rsp_type         pending_results[$];
   int unsigned           mismatch_count;
   int unsigned           hold_requests;
   int unsigned           holds_served;
   bit                    sender_gaps;
   bit                    sink_stalls;
   logic [STAMP_W-1:0]    epoch;

   aging_priority_ready_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_WIDTH   (ID_FIELD_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic sched_req_type enq(input logic [ID_FIELD_W-1:0] pid,
                                         input logic [PRIO_W-1:0] prio,
                                         input logic [STAMP_W-1:0] stamp);
      sched_req_type r;
      r.kind  = REQ_ENQUEUE;
      r.pid   = pid;
      r.prio  = prio;
      r.stamp = stamp;
      r.now   = $urandom;
      return r;
   endfunction

   function automatic sched_req_type deq(input logic [STAMP_W-1:0] now);
      sched_req_type r;
      r.kind  = REQ_DEQUEUE;
      r.pid   = ID_FIELD_W'($urandom);
      r.prio  = $urandom;
      r.stamp = $urandom;
      r.now   = now;
      return r;
   endfunction

   // Applies one request to the local queue copy and returns the response it earns.
   function automatic sched_rsp_type dispatch_request(input sched_req_type r);
      sched_rsp_type      res;
      int unsigned        pick;
      logic [VALUE_W-1:0] best;
      logic [VALUE_W-1:0] cand;
      logic [STAMP_W-1:0] waited;
      res.ok     = 1'b0;
      res.id     = '0;
      res.prio   = '0;
      res.status = STATUS_OK;
      if (r.kind == REQ_ENQUEUE) begin
         if (rq_entries.size() >= QUEUE_DEPTH)
            res.status = STATUS_FULL;
         else
            rq_entries.push_back(ready_entry_type'{id: r.pid, prio: r.prio, stamp: r.stamp});
      end else if (rq_entries.size() == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         pick = 0;
         best = VALUE_W'(rq_entries[0].prio);
         if (rq_aging) begin
            for (int i = 0; i < rq_entries.size(); i++) begin
               waited = r.now - rq_entries[i].stamp;
               cand   = VALUE_W'(rq_entries[i].prio) + VALUE_W'(waited) * VALUE_W'(rq_weight);
               if (i == 0 || cand < best) begin
                  best = cand;
                  pick = i;
               end
            end
         end
         res.ok   = 1'b1;
         res.id   = rq_entries[pick].id;
         res.prio = best;
         rq_entries.delete(pick);
      end
      return res;
   endfunction

   function automatic sched_req_type random_request(input int unsigned enq_pct);
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] now;
      epoch += $urandom_range(0, 2000);
      case ($urandom_range(0, 3))
         0, 1: prio = $urandom_range(0, 15);
         2: prio = $urandom;
         default: prio = 32'hFFFF_FFFF - $urandom_range(0, 15);
      endcase
      stamp = ($urandom_range(0, 3) == 0) ? $urandom : epoch - $urandom_range(0, 50000);
      now   = ($urandom_range(0, 3) == 0) ? $urandom : epoch;
      if ($urandom_range(1, 100) <= enq_pct)
         return enq(ID_FIELD_W'($urandom_range(0, 255)), prio, stamp);
      return deq(now);
   endfunction

   task automatic send_item(input sched_req_type it);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.now, it.stamp, it.prio, it.pid};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(dispatch_request(it));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic aging, input logic [WEIGHT_W-1:0] weight);
      wait_drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_AGING_MODE;
      csr_wdata <= CSR_DATA_W'(aging);
      @(negedge clock);
      csr_addr  <= CSR_AGE_WEIGHT;
      csr_wdata <= weight;
      @(negedge clock);
      csr_we    <= 1'b0;
      rq_aging  = aging;
      rq_weight = weight;
   endtask

   task automatic run_random_phase(input logic aging, input logic [WEIGHT_W-1:0] weight,
                                   input int unsigned count);
      int unsigned enq_pct;
      int unsigned seg_left;
      set_config(aging, weight);
      enq_pct  = 60;
      seg_left = 0;
      repeat (count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(15, 60);
            enq_pct  = (enq_pct >= 50) ? 25 : 80;
         end
         seg_left--;
         send_item(random_request(enq_pct));
      end
      wait_drain();
   endtask

   task automatic test_reset_head_mode();
      send_item(deq($urandom));
      send_item(enq(8'h00, 32'hFFFF_FFFF, 32'h0000_0000));
      send_item(enq(8'hFF, 32'h0000_0000, 32'hFFFF_FFFF));
      send_item(deq(32'h0000_0000));
      send_item(deq(32'hFFFF_FFFF));
      send_item(deq($urandom));
   endtask

   task automatic test_aging_extremes();
      set_config(1'b1, 16'hFFFF);
      send_item(enq(8'h01, 32'hFFFF_FFFF, 32'h0000_0001));
      send_item(enq(8'h02, 32'h0000_0000, 32'h0000_0000));
      send_item(deq(32'h0000_0000));
      send_item(deq(32'h0000_0000));
   endtask

   task automatic test_aging_ties();
      set_config(1'b1, 16'd1);
      send_item(enq(8'h10, 32'd5, 32'd100));
      send_item(enq(8'h11, 32'd4, 32'd99));
      send_item(enq(8'h12, 32'd5, 32'd100));
      send_item(deq(32'd100));
      send_item(deq(32'd100));
      send_item(deq(32'd100));
   endtask

   task automatic test_weightless_aging();
      set_config(1'b1, 16'd0);
      send_item(enq(8'h20, 32'd9, $urandom));
      send_item(enq(8'h21, 32'd3, $urandom));
      send_item(enq(8'h22, 32'd3, $urandom));
      send_item(deq($urandom));
      send_item(deq($urandom));
      send_item(deq($urandom));
      send_item(deq($urandom));
   endtask

   // The sink holds off first; enqueues then overfill the queue and dequeues empty it.
   task automatic test_output_backpressure();
      set_config(1'b1, 16'd3);
      hold_requests++;
      repeat (QUEUE_DEPTH + 6) send_item(random_request(100));
      repeat (QUEUE_DEPTH + 2) send_item(random_request(0));
      wait_drain();
   endtask

   task automatic test_random_traffic();
      run_random_phase(1'b0, WEIGHT_W'($urandom), 150);
      run_random_phase(1'b1, 16'd0, 150);
      run_random_phase(1'b1, 16'd1, 150);
      run_random_phase(1'b1, 16'hFFFF, 150);
      run_random_phase(1'b1, WEIGHT_W'($urandom_range(2, 1000)), 150);
   endtask

   task automatic test_quiet_tail();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      run_random_phase(1'b1, WEIGHT_W'($urandom_range(2, 300)), 120);
   endtask

   initial begin : rsp_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sched_rsp_type want;
      sched_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok     = rsp_tuser[0];
         got.status = status_type'(rsp_tuser[2:1]);
         got.id     = rsp_tdata[7:0];
         got.prio   = rsp_tdata[55:8];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 50)
               $display({"%0t: unexpected beat, expected none,",
                         " actual ok=%0b id=%0h prio=%0h status=%0d"},
                        $time, got.ok, got.id, got.prio, got.status);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.id !== want.id || got.prio !== want.prio ||
                got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 50)
                  $display({"%0t: beat mismatch, expected ok=%0b id=%0h prio=%0h status=%0d,",
                            " actual ok=%0b id=%0h prio=%0h status=%0d"},
                           $time, want.ok, want.id, want.prio, want.status,
                           got.ok, got.id, got.prio, got.status);
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("[aging_priority_ready_queue_top] ERROR");
      $finish;
   end

   initial begin
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_we      = 1'b0;
      csr_addr    = CSR_AGING_MODE;
      csr_wdata   = '0;
      reset       = 1'b1;
      rq_aging    = 1'b0;
      rq_weight   = '0;
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      epoch       = $urandom;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_head_mode();
      test_aging_extremes();
      test_aging_ties();
      test_weightless_aging();
      test_output_backpressure();
      test_random_traffic();
      test_quiet_tail();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[aging_priority_ready_queue_top] OK");
      else
         $display("[aging_priority_ready_queue_top] ERROR");
      $finish;
   end

endmodule
